### rtl/ordered_list_engine_core_defines.svh
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define OLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered list engine check failed");

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered list engine check failed");

`endif

### rtl/ole_pkg.sv
// Types, codes and sizes shared by the ordered list engine modules.
package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int C_AW     = $clog2(CAPACITY);
    localparam int C_CW     = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_POP    = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] entry_value;
        logic [7:0]         position;
    } t_ole_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] popped_value;
        logic [7:0]         found_index;
        logic [7:0]         entry_count;
        logic signed [31:0] head_value;
    } t_ole_out;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       ptr_init;
        logic       rd;
        logic       wr_shift;
        logic       wr_val;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cnt_clr;
        logic       cap_pop;
        logic       cap_found;
        logic       finish;
        logic [2:0] status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       shift_ins;
        logic       pos_ok;
        logic       pos_last;
        logic       rd_valid;
        logic       walk_last;
        logic       match;
    } t_dp_stat;

endpackage

### rtl/ole_ram.sv
// Generic simple dual-port RAM with registered read.
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ole_dp.sv
// Datapath: entry store, count, head copy, walk pointer and result registers.
module ole_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ole_pkg::t_ole_in  i_item,
    input  ole_pkg::t_dp_cmd  i_cmd,
    output ole_pkg::t_dp_stat o_stat,
    output ole_pkg::t_ole_out o_result
);
    import ole_pkg::*;

    logic [2:0]         r_op;
    logic signed [31:0] r_val;
    logic [7:0]         r_pos;
    logic [C_CW-1:0]    r_count;
    logic [C_CW-1:0]    n_count;
    logic signed [31:0] r_head;
    logic [C_AW-1:0]    r_ptr;
    logic [C_AW-1:0]    n_ptr;
    logic [C_AW-1:0]    r_prev;
    logic               r_pend;
    logic [2:0]         r_status;
    logic signed [31:0] r_popped;
    logic [7:0]         r_found;

    logic [C_CW-1:0]    count_m1;
    logic [C_CW-1:0]    ins_pos;
    logic               is_ins;
    logic [C_AW-1:0]    ptr_start;
    logic               we;
    logic [C_AW-1:0]    waddr;
    logic [31:0]        wdata;
    logic [31:0]        rdata;

    assign count_m1 = r_count - 1'b1;
    assign is_ins   = (r_op == OP_INSERT);

    // insert: front, inside strictly before the last slot, else the tail
    always_comb begin
        if (!is_ins || r_count == '0 || r_pos == 8'd0) begin
            ins_pos = is_ins ? '0 : r_count;
        end else if (r_pos < 8'(count_m1)) begin
            ins_pos = C_CW'(r_pos);
        end else begin
            ins_pos = r_count;
        end
    end

    always_comb begin
        if (r_op == OP_REMOVE) begin
            ptr_start = C_AW'(r_pos) + 1'b1;
        end else if (r_op == OP_SEARCH) begin
            ptr_start = '0;
        end else begin
            ptr_start = C_AW'(count_m1);
        end
    end

    // insert walks down from the tail, the others walk up
    assign n_ptr = is_ins ? r_ptr - 1'b1 : r_ptr + 1'b1;

    assign we    = i_cmd.wr_shift | i_cmd.wr_val;
    assign waddr = i_cmd.wr_val ? C_AW'(ins_pos)
                 : (is_ins ? r_prev + 1'b1 : r_prev - 1'b1);
    assign wdata = i_cmd.wr_val ? r_val : rdata;

    ole_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_ptr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.op;
            r_val <= i_item.entry_value;
            r_pos <= i_item.position;
        end
        if (i_cmd.ptr_init) begin
            r_ptr <= ptr_start;
        end else if (i_cmd.rd) begin
            r_ptr <= n_ptr;
        end
        if (i_cmd.rd) begin
            r_prev <= r_ptr;
        end
        // head copy follows every write to slot zero
        if (we && waddr == '0) begin
            r_head <= wdata;
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
            r_popped <= i_cmd.cap_pop ? rdata : '0;
            r_found  <= i_cmd.cap_found ? 8'(r_prev) : 8'd0;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == C_CW'(CAPACITY));
    assign o_stat.shift_ins = is_ins && (ins_pos < r_count);
    assign o_stat.pos_ok    = (r_pos < 8'(r_count));
    assign o_stat.pos_last  = (r_pos == 8'(count_m1));
    assign o_stat.rd_valid  = r_pend;
    assign o_stat.walk_last = is_ins ? (r_ptr == C_AW'(ins_pos))
                                     : (r_ptr == C_AW'(count_m1));
    assign o_stat.match     = (rdata == r_val);

    assign o_result.status       = r_status;
    assign o_result.popped_value = r_popped;
    assign o_result.found_index  = r_found;
    assign o_result.entry_count  = 8'(r_count);
    assign o_result.head_value   = (r_count != '0) ? r_head : '0;
endmodule

### rtl/ole_ctrl.sv
// Controller: sequences decode, memory walks, final write and the result strobe.
module ole_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ole_pkg::t_dp_stat i_stat,
    output ole_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import ole_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_done;
    t_dp_cmd    cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op)
                    OP_APPEND, OP_INSERT: begin
                        if (i_stat.full) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_FULL;
                            n_state    = S_IDLE;
                        end else if (i_stat.shift_ins) begin
                            cmd.ptr_init = 1'b1;
                            n_state      = S_WALK;
                        end else begin
                            cmd.wr_val  = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            cmd.finish  = 1'b1;
                            cmd.status  = ST_OK;
                            n_state     = S_IDLE;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.empty) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_EMPTY;
                            n_state    = S_IDLE;
                        end else if (!i_stat.pos_ok) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_RANGE;
                            n_state    = S_IDLE;
                        end else if (i_stat.pos_last) begin
                            cmd.cnt_dec = 1'b1;
                            cmd.finish  = 1'b1;
                            cmd.status  = ST_OK;
                            n_state     = S_IDLE;
                        end else begin
                            cmd.ptr_init = 1'b1;
                            n_state      = S_WALK;
                        end
                    end
                    OP_POP, OP_SEARCH: begin
                        if (i_stat.empty) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_EMPTY;
                            n_state    = S_IDLE;
                        end else begin
                            cmd.ptr_init = 1'b1;
                            n_state      = S_WALK;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.cnt_clr = 1'b1;
                        cmd.finish  = 1'b1;
                        cmd.status  = i_stat.empty ? ST_EMPTY : ST_OK;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_OK;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                // data of the read issued last cycle is consumed here
                if (i_stat.rd_valid && i_stat.op == OP_SEARCH && i_stat.match) begin
                    cmd.cap_found = 1'b1;
                    cmd.finish    = 1'b1;
                    cmd.status    = ST_OK;
                    n_state       = S_IDLE;
                end else begin
                    cmd.wr_shift = i_stat.rd_valid &&
                                   (i_stat.op == OP_INSERT || i_stat.op == OP_REMOVE);
                    cmd.rd = 1'b1;
                    if (i_stat.walk_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                unique case (i_stat.op)
                    OP_INSERT: begin
                        cmd.wr_shift = 1'b1;
                        n_state      = S_PUT;
                    end
                    OP_REMOVE: begin
                        cmd.wr_shift = 1'b1;
                        cmd.cnt_dec  = 1'b1;
                        cmd.finish   = 1'b1;
                        cmd.status   = ST_OK;
                        n_state      = S_IDLE;
                    end
                    OP_POP: begin
                        cmd.cap_pop = 1'b1;
                        cmd.cnt_dec = 1'b1;
                        cmd.finish  = 1'b1;
                        cmd.status  = ST_OK;
                        n_state     = S_IDLE;
                    end
                    OP_SEARCH: begin
                        cmd.cap_found = i_stat.match;
                        cmd.finish    = 1'b1;
                        cmd.status    = i_stat.match ? ST_OK : ST_NOTFOUND;
                        n_state       = S_IDLE;
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_OK;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_PUT: begin
                cmd.wr_val  = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.finish  = 1'b1;
                cmd.status  = ST_OK;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= cmd.finish;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
endmodule

### rtl/ordered_list_engine_core.sv
// Top level of the ordered list engine: controller plus datapath.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------
//  command  | start, busy       | i_item (op, value, position)
//  result   | o_done (1 cycle)  | o_result (status .. head)
//
// Append, clear, short remove and rejected ops finish from the decode
// state; pop, search and shifting insert/remove first walk the RAM. The
// single-port-pair RAM moves one entry a cycle during a shifting walk.
// Synchronous active-low reset empties the list; entries are not cleared.
// Results cannot be stalled; o_done pulses as busy drops.
`include "ordered_list_engine_core_defines.svh"

module ordered_list_engine_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ole_pkg::t_ole_in  i_item,
    output logic              o_done,
    output ole_pkg::t_ole_out o_result
);
    import ole_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ole_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

    `OLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `OLE_ASSERT_NOW(a_done_idle, o_done, !busy)
    `OLE_ASSERT_NOW(a_count_cap, o_done, o_result.entry_count <= 8'(CAPACITY))
    `OLE_ASSERT_NOW(a_full_count, o_done && o_result.status == ST_FULL,
                    o_result.entry_count == 8'(CAPACITY))
endmodule
